@@ src/datetime_add_minutes_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the date-time minute adder
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef DATETIME_ADD_MINUTES_UNIT_ASSERT_SVH
`define DATETIME_ADD_MINUTES_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DTAM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DTAM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dtam_pkg.sv @@
// ----------------------------------------------------------------------------
// Date-time minute adder package
// Item types, sequencer states, calendar constants and the month table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtam_pkg;

  typedef struct packed {
    logic [5:0]  minute_in;
    logic [4:0]  hour_in;
    logic [4:0]  day_in;
    logic [3:0]  month_in;
    logic [6:0]  year_in;
    logic [15:0] minutes_to_add;
  } req_item_t;

  typedef struct packed {
    logic [5:0] minute_out;
    logic [4:0] hour_out;
    logic [4:0] day_out;
    logic [3:0] month_out;
    logic [6:0] year_out;
  } rsp_item_t;

  // Result of the shared subtract and compare unit.
  typedef struct packed {
    logic [6:0] diff;
    logic       ge;
    logic       gt;
  } alu_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_REM,
    S_HREM,
    S_MIN,
    S_HOUR,
    S_MONTH,
    S_DONE
  } state_t;

  localparam logic [6:0]  MINUTES_PER_HOUR = 7'd60;
  localparam logic [6:0]  HOURS_PER_DAY    = 7'd24;
  localparam logic [6:0]  LAST_YEAR        = 7'd99;
  localparam logic [3:0]  LAST_MONTH       = 4'd12;
  localparam logic [3:0]  FEBRUARY         = 4'd2;
  localparam logic [4:0]  FEB_DAYS_LEAP    = 5'd29;

  // x / 15 = (x * RECIP_15) >> RECIP_15_SHIFT, exact for x below 16384.
  localparam logic [15:0] RECIP_15         = 16'h8889;
  localparam int          RECIP_15_SHIFT   = 19;
  // y / 3 = (y * RECIP_3) >> RECIP_3_SHIFT, exact for y below 256.
  localparam logic [8:0]  RECIP_3          = 9'd171;
  localparam int          RECIP_3_SHIFT    = 9;

  localparam logic [4:0] DAYS_IN_MONTH [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Length of a month; months outside 1..12 have no days at all.
  function automatic logic [4:0] month_days(input logic [6:0] year,
                                            input logic [3:0] month);
    logic [3:0] idx;
    logic [4:0] len;
    idx = month - 4'd1;
    if (month == 4'd0 || month > LAST_MONTH) begin
      len = 5'd0;
    end else if (month == FEBRUARY) begin
      len = (year[1:0] == 2'b00) ? FEB_DAYS_LEAP : DAYS_IN_MONTH[idx];
    end else begin
      len = DAYS_IN_MONTH[idx];
    end
    return len;
  endfunction

endpackage

@@ src/dtam_alu.sv @@
// ----------------------------------------------------------------------------
// Date-time minute adder subtract and compare unit
// One subtractor shared by the minute, hour and month fold steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtam_alu
  import dtam_pkg::*;
(
  input  logic [6:0] a,
  input  logic [6:0] b,
  output alu_res_t   res
);

  logic [7:0] diff_w;

  assign diff_w   = {1'b0, a} - {1'b0, b};
  assign res.diff = diff_w[6:0];
  assign res.ge   = ~diff_w[7];
  // Strictly greater: no borrow and a nonzero difference.
  assign res.gt   = ~diff_w[7] & (diff_w[6:0] != 7'd0);

endmodule

@@ src/datetime_add_minutes_unit.sv @@
// ----------------------------------------------------------------------------
// Date-time minute adder
// Advances a binary date-time with a two-digit year by a count of minutes.
// ----------------------------------------------------------------------------
// One item is worked on at a time. After an item is accepted, the steps
// S_DIV, S_REM and S_HREM split the count into minutes, hours and days with
// reciprocal multiplies. S_MIN folds the minute carry. S_HOUR repeats until
// the hour is below 24, folding it into days. S_MONTH repeats to roll the
// day count across month ends. S_DONE loads the output register, and the
// next item can be accepted in the cycle after that. If an earlier result
// is still waiting, the sequencer holds in its last step until that result
// is taken. The minute, hour and month folds all run on a single shared
// subtract and compare unit.
// The request side is ready only while the sequencer is idle. A finished
// result waits in the output register, so a new item can be accepted while
// the previous result is still unclaimed. All fields are binary. February
// has 29 days in years divisible by four (year 00 included), the year wraps
// from 99 to 0, and a month code outside 1 to 12 counts as a month with no
// days. There is no memory and no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module datetime_add_minutes_unit
  import dtam_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  `include "datetime_add_minutes_unit_assert.svh"

  state_t state, state_next;

  // Working registers of the item in flight.
  logic [15:0] count;
  logic [10:0] q60;       // whole hours in the count
  logic [5:0]  min_add;   // minutes part of the count
  logic [5:0]  add_day;   // whole days in the count
  logic [4:0]  add_hr;    // hours part of the count
  logic [6:0]  min_acc;
  logic [5:0]  hour_acc;
  logic [6:0]  day_acc;
  logic [3:0]  month_acc;
  logic [6:0]  year_acc;

  // Arithmetic for the split of the count.
  logic [29:0] prod60;
  logic [16:0] q60_x60;
  logic [16:0] rem60;
  logic [16:0] prod3;
  logic [10:0] day_x24;
  logic [10:0] hrem;

  logic [4:0]  md;
  logic [6:0]  alu_a, alu_b;
  alu_res_t    alu;
  logic        out_free;

  // count / 60 is (count / 4) / 15, done with a reciprocal multiply.
  assign prod60  = count[15:2] * RECIP_15;
  assign q60_x60 = {q60, 6'b0} - {4'b0, q60, 2'b0};
  assign rem60   = {1'b0, count} - q60_x60;
  // hours / 24 is (hours / 8) / 3.
  assign prod3   = q60[10:3] * RECIP_3;
  assign day_x24 = {add_day, 4'b0} + {1'b0, add_day, 3'b0};
  assign hrem    = q60 - day_x24;

  assign md = month_days(year_acc, month_acc);

  // The shared unit compares against the hour length in the minute fold,
  // the day length in the hour fold and the month length in the day roll.
  always_comb begin
    unique case (state)
      S_MIN: begin
        alu_a = min_acc;
        alu_b = MINUTES_PER_HOUR;
      end
      S_HOUR: begin
        alu_a = {1'b0, hour_acc};
        alu_b = HOURS_PER_DAY;
      end
      default: begin
        alu_a = day_acc;
        alu_b = {2'b0, md};
      end
    endcase
  end

  dtam_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  assign req_ready = (state == S_IDLE);
  assign out_free  = ~rsp_valid | rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_valid) state_next = S_DIV;
      S_DIV:   state_next = S_REM;
      S_REM:   state_next = S_HREM;
      S_HREM:  state_next = S_MIN;
      S_MIN:   state_next = S_HOUR;
      S_HOUR:  if (!alu.ge) state_next = S_MONTH;
      S_MONTH: if (!alu.gt) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath: one step of the item per state.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          count     <= req.minutes_to_add;
          min_acc   <= {1'b0, req.minute_in};
          hour_acc  <= {1'b0, req.hour_in};
          day_acc   <= {2'b0, req.day_in};
          month_acc <= req.month_in;
          year_acc  <= req.year_in;
        end
      end
      S_DIV: begin
        q60 <= prod60[29:19];
      end
      S_REM: begin
        min_add <= rem60[5:0];
        add_day <= prod3[14:9];
      end
      S_HREM: begin
        add_hr  <= hrem[4:0];
        min_acc <= min_acc + {1'b0, min_add};
      end
      S_MIN: begin
        // The minute sum is reduced by one hour at most once.
        if (alu.ge) begin
          min_acc <= alu.diff;
        end
        hour_acc <= hour_acc + {1'b0, add_hr} + {5'b0, alu.ge};
        day_acc  <= day_acc + {1'b0, add_day};
      end
      S_HOUR: begin
        if (alu.ge) begin
          hour_acc <= alu.diff[5:0];
          day_acc  <= day_acc + 7'd1;
        end
      end
      S_MONTH: begin
        if (alu.gt) begin
          day_acc <= alu.diff;
          if (month_acc >= LAST_MONTH) begin
            month_acc <= 4'd1;
            year_acc  <= (year_acc >= LAST_YEAR) ? 7'd0 : year_acc + 7'd1;
          end else begin
            month_acc <= month_acc + 4'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished result waits here until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.minute_out <= min_acc[5:0];
      rsp.hour_out   <= hour_acc[4:0];
      rsp.day_out    <= day_acc[4:0];
      rsp.month_out  <= month_acc;
      rsp.year_out   <= year_acc;
    end
  end

  `DTAM_ASSERT_NOW(a_q60_range, state == S_REM, q60 <= 11'd1092, "hour count out of range")
  `DTAM_ASSERT_NOW(a_min_folded, state == S_HOUR, min_acc < 7'd64, "minute fold left a large minute")
  `DTAM_ASSERT_NOW(a_hour_folded, state == S_MONTH, hour_acc < 6'd24, "hour fold incomplete")
  `DTAM_ASSERT_NEXT(a_done_holds, state == S_DONE && rsp_valid && !rsp_ready, state == S_DONE, "result overwrote a waiting item")

endmodule
